// ===== design/scf_pkg.sv =====
// Shared types, constants and helper functions for the stereo chorus/flanger.
// Used by the multiplier and the top-level datapath; no dependencies.
package scf_pkg;

  // Delay line geometry
  localparam int LINE_DEPTH = 2048;
  localparam int LINE_BITS  = $clog2(LINE_DEPTH);
  localparam int MARGIN     = 6;

  // Sine table resolution and sample format
  localparam int SINE_POINTS = 1024;
  localparam int SINE_BITS   = $clog2(SINE_POINTS);
  localparam int SAMPLE_BITS = 16;
  localparam int DFRAC       = 8;
  localparam int DELAY_W     = 19;
  localparam int DSUM_W      = 22;

  // Polynomial sine coefficients, Q15
  localparam int SIN_A = 51436;
  localparam int SIN_B = 20953;
  localparam int SIN_C = 2285;

  // Interpolation weights are the cubic products scaled down by this shift
  localparam int WSH = 3 * DFRAC - 16;

  // Division by three through a reciprocal: floor(u / 3) = (u * RECIP_M) >> RECIP_SH
  localparam int RECIP_SH  = 25;
  localparam int RECIP_M   = ((1 << RECIP_SH) + 2) / 3;
  localparam int DIV_BIAS  = 3 << 20;

  // Shared multiplier widths
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // Register map
  typedef enum logic [2:0] {
    REG_BASE_DELAY,
    REG_SWEEP_DEPTH,
    REG_FEEDBACK,
    REG_FORWARD_GAIN,
    REG_MIX_GAIN,
    REG_LEFT_STEP,
    REG_RIGHT_STEP,
    REG_MODE
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_PHASE, S_SQ, S_X2, S_T1, S_T2, S_SIN, S_LFO,
    S_CLAMP,
    S_W0, S_W1, S_W2, S_W3, S_W4, S_W5, S_W6, S_W7, S_W8,
    S_M0, S_M1, S_M2, S_M3, S_M4,
    S_R0, S_R1,
    S_FB, S_X1, S_MIX, S_FWD, S_RES,
    S_DONE
  } state_t;

  // Saturate a wide signed value to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [39:0] v);
    logic signed [39:0] smax;
    logic signed [39:0] smin;
    smax = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
    smin = -(40'sd1 <<< (SAMPLE_BITS - 1));
    if (v > smax) return smax[SAMPLE_BITS-1:0];
    if (v < smin) return smin[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== design/scf_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on scf_pkg for the operand and product widths.
module scf_mul
  import scf_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  // One product per cycle, available in the following cycle.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== design/stereo_chorus_flanger.sv =====
// Stereo chorus/flanger: sequencer, delay-line memory and register file.
// Depends on scf_pkg and the shared multiplier scf_mul.
//
// Usage: one mono sample enters on the in_* channel and one transaction with
// a left and a right sample leaves on the out_* channel. A channel moves a
// transaction at a rising edge where valid is high and stall is low.
// Each sample is processed by a sequencer around one 25x25 multiplier, which
// carries the sine polynomial, the LFO scaling, the Lagrange weights, the
// four-tap sum, the divide by six and the gains, with in_stall high
// throughout. The next sample is accepted as soon as the result has been
// loaded into the output register, even while the receiver still stalls it;
// if the previous result has not been taken, the finished one waits in the
// sequencer. Reset returns the registers to their defaults, resets the LFO
// phases and the write pointer. The lines are not swept: a fill count marks
// which entries have been written and unwritten entries read as zero, so no
// idle time follows reset. Configuration is to be written through the APB
// port between samples; the block itself does not enforce this.
module stereo_chorus_flanger
  import scf_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input samples
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  // Output samples
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_sample,
  output logic signed [SAMPLE_BITS-1:0] right_sample
);

  localparam logic [DSUM_W-1:0] D_LO   = DSUM_W'(MARGIN << DFRAC);
  localparam logic [DSUM_W-1:0] D_HI   = DSUM_W'((LINE_DEPTH - MARGIN) << DFRAC);
  localparam logic [DSUM_W-1:0] D_MARG = DSUM_W'(MARGIN << DFRAC);
  localparam int FW = DFRAC + 3;

  // Configuration registers
  logic [DELAY_W-1:0]            base_delay;
  logic [DELAY_W-1:0]            sweep_depth;
  logic signed [15:0]            feedback;
  logic signed [15:0]            forward_gain;
  logic signed [15:0]            mix_gain;
  logic [31:0]                   left_phase_step;
  logic [31:0]                   right_phase_step;
  logic                          mode;
  logic                          cfg_wr;

  // Sequencer control
  state_t                        state;
  state_t                        state_next;
  logic                          ch;
  logic                          pass;
  logic [LINE_BITS-1:0]          wp;
  logic [LINE_BITS:0]            fill;
  logic [31:0]                   left_phase;
  logic [31:0]                   right_phase;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] xin;
  logic [16:0]                   xq;
  logic                          neg_half;
  logic [16:0]                   x2;
  logic [DSUM_W-1:0]             dsum;
  logic [DFRAC-1:0]              frac;
  logic [LINE_BITS-1:0]          rd_base;
  logic [1:0]                    rd_j;
  logic                          rd_pend;
  logic [1:0]                    rd_pend_idx;
  logic signed [21:0]            w [4];
  logic signed [15:0]            y [4];
  logic signed [37:0]            acc;
  logic signed [20:0]            tap;
  logic signed [20:0]            fbt;
  logic signed [SAMPLE_BITS-1:0] x1;
  logic signed [36:0]            mix_acc;
  logic signed [SAMPLE_BITS-1:0] l_res;
  logic signed [SAMPLE_BITS-1:0] r_res;

  // Shared multiplier
  logic signed [MUL_W-1:0]       mul_a;
  logic signed [MUL_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]      prod;

  // Delay-line memory, left line in the lower half
  logic [15:0]                   line_mem [2*LINE_DEPTH];
  logic [15:0]                   rd_data;
  logic                          rd_ok;
  logic [LINE_BITS-1:0]          rd_addr;
  logic                          rd_issue;
  logic                          mem_we;

  // Combinational helpers
  logic [31:0]                   phase_sum;
  logic [SINE_BITS-1:0]          k_idx;
  logic [15:0]                   angle;
  logic [16:0]                   t_val;
  logic [16:0]                   s_raw;
  logic [14:0]                   s_cap;
  logic [16:0]                   sv;
  logic [DSUM_W-1:0]             dcl;
  logic [LINE_BITS-1:0]          tap_i;
  logic signed [FW-1:0]          fs;
  logic signed [FW-1:0]          fm1;
  logic signed [FW-1:0]          fm2;
  logic signed [FW-1:0]          fm3;
  logic signed [PROD_W-1:0]      prod3;
  logic signed [20:0]            dv;
  logic [22:0]                   du;
  logic signed [20:0]            tap_val;
  logic signed [23:0]            xsum;
  logic signed [SAMPLE_BITS-1:0] x1_val;
  logic signed [37:0]            out_sum;
  logic                          out_load;

  scf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay       <= DELAY_W'(8192);
      sweep_depth      <= DELAY_W'(1024);
      feedback         <= 16'sd0;
      forward_gain     <= 16'sd16384;
      mix_gain         <= 16'sd8192;
      left_phase_step  <= 32'd26844;
      right_phase_step <= 32'd35791;
      mode             <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_BASE_DELAY:   base_delay       <= pwdata[DELAY_W-1:0];
        REG_SWEEP_DEPTH:  sweep_depth      <= pwdata[DELAY_W-1:0];
        REG_FEEDBACK:     feedback         <= pwdata[15:0];
        REG_FORWARD_GAIN: forward_gain     <= pwdata[15:0];
        REG_MIX_GAIN:     mix_gain         <= pwdata[15:0];
        REG_LEFT_STEP:    left_phase_step  <= pwdata;
        REG_RIGHT_STEP:   right_phase_step <= pwdata;
        REG_MODE:         mode             <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_BASE_DELAY:   prdata = 32'(base_delay);
      REG_SWEEP_DEPTH:  prdata = 32'(sweep_depth);
      REG_FEEDBACK:     prdata = {16'd0, feedback};
      REG_FORWARD_GAIN: prdata = {16'd0, forward_gain};
      REG_MIX_GAIN:     prdata = {16'd0, mix_gain};
      REG_LEFT_STEP:    prdata = left_phase_step;
      REG_RIGHT_STEP:   prdata = right_phase_step;
      REG_MODE:         prdata = {31'd0, mode};
      default:          prdata = 32'd0;
    endcase
  end

  // Phase advance and quarter-wave folding of the rounded table index
  assign phase_sum = (ch ? right_phase : left_phase) + (ch ? right_phase_step : left_phase_step);
  assign k_idx     = phase_sum[31 -: SINE_BITS] + SINE_BITS'(phase_sum[31 - SINE_BITS]);
  assign angle     = {k_idx, {(16 - SINE_BITS){1'b0}}};

  // Sine polynomial steps, each taking the previous product
  assign t_val = 17'(SIN_B) - prod[31:15];
  assign s_raw = prod[31:15];
  assign s_cap = (s_raw > 17'd32767) ? 15'h7FFF : s_raw[14:0];
  assign sv    = neg_half ? (17'd32768 - 17'(s_cap)) : (17'd32768 + 17'(s_cap));

  // Delay clamp and tap position
  assign dcl   = (dsum < D_LO) ? D_LO : ((dsum > D_HI) ? D_HI : dsum);
  assign tap_i = dcl[DFRAC +: LINE_BITS];

  // Lagrange factors p, p-1, p-2, p-3 in units of one fraction step
  assign fs  = $signed(FW'(frac));
  assign fm1 = fs - FW'(1 << DFRAC);
  assign fm2 = fs - FW'(2 << DFRAC);
  assign fm3 = fs - FW'(3 << DFRAC);
  assign prod3 = prod + (prod <<< 1);

  // Divide the tap sum by 6 * 65536: shift by 17, then bias and divide by three
  assign dv      = acc[37:17];
  assign du      = 23'($unsigned(23'(dv))) + 23'(DIV_BIAS);
  assign tap_val = 21'(prod[45:RECIP_SH]) - 21'sd1048576;

  // Line input with feedback, clipped
  assign xsum   = 24'(xin) + 24'($signed(prod[37:15]));
  assign x1_val = sat_sample(40'(xsum));

  assign out_sum  = 38'(mix_acc) + 38'($signed(prod[36:0]));
  assign out_load = (state == S_DONE) && !(out_valid && out_stall);

  // Memory access
  assign rd_issue = (state == S_W0) || (state == S_W1) || (state == S_W2) || (state == S_W3);
  assign rd_addr  = rd_base - LINE_BITS'(rd_j);
  assign mem_we   = (state == S_X1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[{ch, wp}] <= x1_val;
    end
    rd_data <= line_mem[{ch, rd_addr}];
    rd_ok   <= fill[LINE_BITS] | ({1'b0, LINE_BITS'(rd_addr + 1'b1)} < fill);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operand selection
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_PHASE;
      S_PHASE: state_next = S_SQ;
      S_SQ: begin
        mul_a = MUL_W'(xq);
        mul_b = MUL_W'(xq);
        state_next = S_X2;
      end
      S_X2: begin
        mul_a = MUL_W'(prod[31:15]);
        mul_b = MUL_W'(SIN_C);
        state_next = S_T1;
      end
      S_T1: begin
        mul_a = MUL_W'(x2);
        mul_b = MUL_W'(t_val);
        state_next = S_T2;
      end
      S_T2: begin
        mul_a = MUL_W'(xq);
        mul_b = MUL_W'(17'(SIN_A) - prod[31:15]);
        state_next = S_SIN;
      end
      S_SIN: begin
        mul_a = MUL_W'(sweep_depth);
        mul_b = MUL_W'(sv);
        state_next = S_LFO;
      end
      S_LFO:   state_next = S_CLAMP;
      S_CLAMP: state_next = S_W0;
      S_W0: begin
        mul_a = MUL_W'(fm1);
        mul_b = MUL_W'(fm2);
        state_next = S_W1;
      end
      S_W1: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(fm3);
        state_next = S_W2;
      end
      S_W2: begin
        mul_a = MUL_W'(fm2);
        mul_b = MUL_W'(fm3);
        state_next = S_W3;
      end
      S_W3: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(fs);
        state_next = S_W4;
      end
      S_W4: begin
        mul_a = MUL_W'(fm1);
        mul_b = MUL_W'(fm3);
        state_next = S_W5;
      end
      S_W5: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(fs);
        state_next = S_W6;
      end
      S_W6: begin
        mul_a = MUL_W'(fm1);
        mul_b = MUL_W'(fm2);
        state_next = S_W7;
      end
      S_W7: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(fs);
        state_next = S_W8;
      end
      S_W8: state_next = S_M0;
      S_M0: begin
        mul_a = MUL_W'(w[0]);
        mul_b = MUL_W'(y[0]);
        state_next = S_M1;
      end
      S_M1: begin
        mul_a = MUL_W'(w[1]);
        mul_b = MUL_W'(y[1]);
        state_next = S_M2;
      end
      S_M2: begin
        mul_a = MUL_W'(w[2]);
        mul_b = MUL_W'(y[2]);
        state_next = S_M3;
      end
      S_M3: begin
        mul_a = MUL_W'(w[3]);
        mul_b = MUL_W'(y[3]);
        state_next = S_M4;
      end
      S_M4: state_next = S_R0;
      S_R0: begin
        mul_a = MUL_W'(du);
        mul_b = MUL_W'(RECIP_M);
        state_next = S_R1;
      end
      S_R1: begin
        if (!pass && mode) begin
          state_next = S_CLAMP;
        end else begin
          state_next = S_FB;
        end
      end
      S_FB: begin
        mul_a = MUL_W'(feedback);
        mul_b = MUL_W'(fbt);
        state_next = S_X1;
      end
      S_X1: state_next = S_MIX;
      S_MIX: begin
        mul_a = MUL_W'(mix_gain);
        mul_b = MUL_W'(x1);
        state_next = S_FWD;
      end
      S_FWD: begin
        mul_a = MUL_W'(forward_gain);
        mul_b = MUL_W'(tap);
        state_next = S_RES;
      end
      S_RES:   state_next = ch ? S_DONE : S_PHASE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Control state: phases, write pointer, fill count, channel, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      left_phase  <= 32'h4000_0000;
      right_phase <= 32'd0;
      wp          <= LINE_BITS'(LINE_DEPTH - 1);
      fill        <= '0;
      ch          <= 1'b0;
      pass        <= 1'b0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: ch <= 1'b0;
        S_PHASE: begin
          pass <= 1'b0;
          if (ch) right_phase <= phase_sum;
          else    left_phase  <= phase_sum;
        end
        S_R1:   if (!pass && mode) pass <= 1'b1;
        S_RES:  ch <= 1'b1;
        S_DONE: begin
          if (out_load) begin
            wp <= wp + 1'b1;
            if (!fill[LINE_BITS]) fill <= fill + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      y[rd_pend_idx] <= rd_ok ? $signed(rd_data) : 16'sd0;
    end
    rd_pend_idx <= rd_j;
    if (rd_issue) rd_j <= rd_j + 1'b1;
    case (state)
      S_IDLE: xin <= in_sample;
      S_PHASE: begin
        neg_half <= angle[15];
        xq <= angle[14] ? (17'd32768 - {2'b0, angle[13:0], 1'b0}) : {2'b0, angle[13:0], 1'b0};
      end
      S_X2:  x2 <= prod[31:15];
      S_LFO: dsum <= DSUM_W'(base_delay) + DSUM_W'(prod[35:15]) + D_MARG;
      S_CLAMP: begin
        frac    <= dcl[DFRAC-1:0];
        rd_base <= wp - tap_i;
        rd_j    <= 2'd0;
      end
      S_W2: w[0] <= 22'((-prod) >>> WSH);
      S_W4: w[1] <= 22'(prod3 >>> WSH);
      S_W6: w[2] <= 22'((-prod3) >>> WSH);
      S_W8: w[3] <= 22'(prod >>> WSH);
      S_M0: acc <= '0;
      S_M1, S_M2, S_M3, S_M4: acc <= acc + 38'(prod);
      S_R1: begin
        if (!pass) tap <= tap_val;
        if (!pass && mode) dsum <= DSUM_W'(base_delay) + D_MARG;
        else               fbt  <= tap_val;
      end
      S_X1:  x1 <= x1_val;
      S_FWD: mix_acc <= prod[36:0];
      S_RES: begin
        if (ch) r_res <= sat_sample(40'(out_sum >>> 14));
        else    l_res <= sat_sample(40'(out_sum >>> 14));
      end
      S_DONE: begin
        if (out_load) begin
          left_sample  <= l_res;
          right_sample <= r_res;
        end
      end
      default: ;
    endcase
  end

  // The fill count saturates at the line length.
  assert property (@(posedge clk) disable iff (rst) fill <= (LINE_BITS+1)'(LINE_DEPTH))
    else $error("fill count beyond line length");

  // An accepted sample always starts with the left channel's phase step.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PHASE) && !ch)
    else $error("sample accepted without starting the left channel");

  // The clamped read index keeps all four taps clear of the write position.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_W0) |-> (LINE_BITS'(wp - rd_base) >= LINE_BITS'(MARGIN)) &&
                        (LINE_BITS'(wp - rd_base) <= LINE_BITS'(LINE_DEPTH - MARGIN)))
    else $error("tap index outside the clamped range");

  // The write pointer moves by one exactly when a result is loaded.
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> wp == LINE_BITS'($past(wp) + 1'b1))
    else $error("write pointer did not advance with the result");

endmodule
